// File: src/decimal_lsd_radix_sort_macros.svh
// Assertion macros shared by the sort block.
`ifndef DECIMAL_LSD_RADIX_SORT_MACROS_SVH
`define DECIMAL_LSD_RADIX_SORT_MACROS_SVH
// Same-cycle implication.
`define DLRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define DLRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/dlrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal radix sort package
// Shared constants for the decimal radix sort block.
// ----------------------------------------------------------------------------
package dlrs_pkg;
  localparam int unsigned Radix     = 10;
  localparam int unsigned ValueW    = 31;
  localparam int unsigned DigitW    = 4;
  // Reciprocal of ten for an exact divide of any 32-bit value: (q * Recip10) >> 35.
  localparam logic [31:0] Recip10   = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;
endpackage

// File: src/dlrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dlrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: src/decimal_lsd_radix_sort.sv
`timescale 1ns / 1ps
// Load: one word per cycle, busy stays low until the word with is_last.
// Sort: one pass per decimal digit of the largest value, each one a scatter
// into the bucket RAM and a gather back, through the single read port of each RAM.
// Emit: n results on consecutive cycles after the sort.
// Reset clears the control state only; the RAMs hold no reset value.
// ----------------------------------------------------------------------------
// Decimal LSD radix sort
// Collects a set of values, sorts them by decimal digits through a bucket
// RAM and streams them out in ascending order.
// ----------------------------------------------------------------------------
module decimal_lsd_radix_sort import dlrs_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ValueW-1:0] value_i,
  input  logic              is_last_i,
  output logic              result_valid_o,
  output logic [ValueW-1:0] sorted_value_o,
  output logic              is_final_o
);
  localparam int unsigned IW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned BD = Radix * MAX_ELEMENTS;
  localparam int unsigned BW = $clog2(BD);
  localparam int unsigned EW = 2 * ValueW;
  localparam int unsigned PW = ValueW + 32;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScat = 2'd1;
  localparam logic [1:0] StGath = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, iss_q, iss_d, j_q, j_d, k_q, k_d;
  logic [DigitW-1:0] b_q, b_d;
  logic [CW-1:0] bcnt_q [Radix];
  logic [CW-1:0] bcnt_d [Radix];
  logic nz_q, nz_d, v1_q, v2_q, gv_q, ev_q, elast_q;
  logic [PW-1:0] prod_q;
  logic [ValueW-1:0] q2_q, val2_q;

  // Element word holds the value and its remaining quotient.
  logic          e_we;
  logic [IW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  logic          b_we;
  logic [BW-1:0] b_waddr, b_raddr;
  logic [EW-1:0] b_rdata;

  logic accept, scat_iss, gath_iss, emit_iss;
  logic [ValueW-4:0] qd;
  logic [DigitW-1:0] dig;

  dlrs_ram #(.WIDTH(EW), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  dlrs_ram #(.WIDTH(EW), .DEPTH(BD)) u_bucket_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i({val2_q, ValueW'(qd)}),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  assign qd  = prod_q[PW-1:RecipShift];
  assign dig = DigitW'(q2_q - ValueW'(qd) * ValueW'(10));

  assign scat_iss = (state_q == StScat) && (iss_q < n_q);
  assign emit_iss = (state_q == StEmit) && (iss_q < n_q);
  assign gath_iss = (state_q == StGath) && (b_q < DigitW'(Radix)) &&
                    (j_q < bcnt_q[b_q]);

  assign e_raddr = iss_q[IW-1:0];
  assign b_raddr = BW'(BW'(b_q) * BW'(MAX_ELEMENTS) + BW'(j_q));
  assign b_we    = v2_q;
  assign b_waddr = BW'(BW'(dig) * BW'(MAX_ELEMENTS) + BW'(bcnt_q[dig]));

  always_comb begin
    if (state_q == StIdle) begin
      e_we    = accept && (cnt_q < CW'(MAX_ELEMENTS));
      e_waddr = cnt_q[IW-1:0];
      e_wdata = {value_i, value_i};
    end else begin
      e_we    = gv_q;
      e_waddr = k_q[IW-1:0];
      e_wdata = b_rdata;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    iss_d   = iss_q;
    j_d     = j_q;
    k_d     = k_q;
    b_d     = b_q;
    nz_d    = nz_q;
    bcnt_d  = bcnt_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (cnt_q < CW'(MAX_ELEMENTS)) begin
            cnt_d = cnt_q + 1'b1;
            nz_d  = nz_q || (value_i != '0);
          end
          if (is_last_i) begin
            n_d   = cnt_d;
            cnt_d = '0;
            iss_d = '0;
            nz_d  = 1'b0;
            for (int r = 0; r < Radix; r++) bcnt_d[r] = '0;
            state_d = (nz_q || (value_i != '0 && cnt_q < CW'(MAX_ELEMENTS)))
                      ? StScat : StEmit;
          end
        end
      end
      StScat: begin
        if (scat_iss) iss_d = iss_q + 1'b1;
        if (v2_q) begin
          bcnt_d[dig] = bcnt_q[dig] + 1'b1;
          nz_d = nz_q || (qd != '0);
        end
        if (iss_q == n_q && !v1_q && !v2_q) begin
          state_d = StGath;
          b_d = '0;
          j_d = '0;
          k_d = '0;
        end
      end
      StGath: begin
        if (gath_iss) begin
          j_d = j_q + 1'b1;
        end else if (b_q < DigitW'(Radix)) begin
          b_d = b_q + 1'b1;
          j_d = '0;
        end
        if (gv_q) k_d = k_q + 1'b1;
        if (b_q == DigitW'(Radix) && !gv_q) begin
          iss_d = '0;
          nz_d  = 1'b0;
          for (int r = 0; r < Radix; r++) bcnt_d[r] = '0;
          // Another pass is needed while any quotient is still nonzero.
          state_d = nz_q ? StScat : StEmit;
        end
      end
      StEmit: begin
        if (emit_iss) iss_d = iss_q + 1'b1;
        if (iss_q == n_q && !ev_q) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      n_q     <= '0;
      iss_q   <= '0;
      j_q     <= '0;
      k_q     <= '0;
      b_q     <= '0;
      nz_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      gv_q    <= 1'b0;
      ev_q    <= 1'b0;
      elast_q <= 1'b0;
      for (int r = 0; r < Radix; r++) bcnt_q[r] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      iss_q   <= iss_d;
      j_q     <= j_d;
      k_q     <= k_d;
      b_q     <= b_d;
      nz_q    <= nz_d;
      v1_q    <= scat_iss;
      v2_q    <= v1_q;
      gv_q    <= gath_iss;
      ev_q    <= emit_iss;
      elast_q <= emit_iss && (iss_q + 1'b1 == n_q);
      bcnt_q  <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(e_rdata[ValueW-1:0]) * PW'(Recip10);
    q2_q   <= e_rdata[ValueW-1:0];
    val2_q <= e_rdata[EW-1:ValueW];
  end

  assign result_valid_o = ev_q;
  assign sorted_value_o = e_rdata[EW-1:ValueW];
  assign is_final_o     = ev_q && elast_q;

`include "decimal_lsd_radix_sort_macros.svh"

  `DLRS_ASSERT_NOW(a_valid_in_emit, result_valid_o, state_q == StEmit, "result outside emit")
  `DLRS_ASSERT_NOW(a_final_valid, is_final_o, result_valid_o, "final flag without result")
  `DLRS_ASSERT_NEXT(a_close_busy, accept && is_last_i, busy, "set closed but not busy")
  `DLRS_ASSERT_NOW(a_bucket_dig, v2_q, dig < DigitW'(Radix), "digit out of range")
endmodule

// File: bench/decimal_lsd_radix_sort_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal radix sort testbench
// Loads sets of values, predicts their ascending order in a local sorter and
// checks every emitted word and its final flag against that prediction.
// ----------------------------------------------------------------------------
module decimal_lsd_radix_sort_tb;
  import dlrs_pkg::*;

  localparam int unsigned MaxElems = 64;
  localparam int unsigned IdleLimit = 100000;
  localparam int unsigned TailCycles = 50;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_final;
  } sorted_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ValueW-1:0] value_i = '0;
  logic              is_last_i = 1'b0;
  logic              result_valid_o;
  logic [ValueW-1:0] sorted_value_o;
  logic              is_final_o;

  decimal_lsd_radix_sort #(.MAX_ELEMENTS(MaxElems)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .value_i(value_i), .is_last_i(is_last_i), .result_valid_o(result_valid_o),
    .sorted_value_o(sorted_value_o), .is_final_o(is_final_o)
  );

  always #2 clk_i = ~clk_i;

  logic [ValueW-1:0] set_values[$];
  sorted_word_t      sorted_queue[$];
  int unsigned       errors = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left = 0;

  // Stable decimal LSD sort of the open set; the store-full rule drops extras.
  task automatic predict_sorted_set();
    logic [ValueW-1:0] elems[$];
    logic [ValueW-1:0] buckets[Radix][$];
    logic [ValueW-1:0] largest;
    longint unsigned   weight;
    int unsigned       passes;
    int unsigned       dig;
    elems = set_values;
    largest = '0;
    foreach (elems[i]) if (elems[i] > largest) largest = elems[i];
    passes = 0;
    while (largest != 0) begin
      largest = ValueW'(largest / Radix);
      passes++;
    end
    weight = 1;
    for (int p = 0; p < passes; p++) begin
      for (int b = 0; b < Radix; b++) buckets[b].delete();
      foreach (elems[i]) begin
        dig = 32'((longint'(elems[i]) / weight) % Radix);
        buckets[dig].push_back(elems[i]);
      end
      elems.delete();
      for (int b = 0; b < Radix; b++) foreach (buckets[b][j]) elems.push_back(buckets[b][j]);
      weight = weight * Radix;
    end
    foreach (elems[i]) sorted_queue.push_back('{elems[i], i == elems.size() - 1});
    set_values.delete();
  endtask

  // Sends one word, with bursts and random gaps on the sender side.
  // Within a burst start stays high from one word to the next.
  task automatic send_word(input logic [ValueW-1:0] v, input logic last);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    value_i <= v;
    is_last_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (set_values.size() < MaxElems) set_values.push_back(v);
    if (last) predict_sorted_set();
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (sorted_queue.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_set(input int unsigned n, input logic narrow);
    logic [ValueW-1:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: v = ValueW'($urandom_range(0, 9));
        1: v = ValueW'($urandom_range(0, 99999));
        default: v = narrow ? ValueW'($urandom_range(0, 999)) : ValueW'($urandom);
      endcase
      send_word(v, i == n - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (sorted_queue.size() == 0) begin
        $display("%0t unexpected word: actual %0d final %0b", $time, sorted_value_o,
                 is_final_o);
        errors++;
      end else begin
        if (sorted_value_o !== sorted_queue[0].value) begin
          $display("%0t sorted value: expected %0d actual %0d", $time,
                   sorted_queue[0].value, sorted_value_o);
          errors++;
        end
        if (is_final_o !== sorted_queue[0].is_final) begin
          $display("%0t final flag: expected %0b actual %0b", $time,
                   sorted_queue[0].is_final, is_final_o);
          errors++;
        end
        void'(sorted_queue.pop_front());
      end
    end
  end

  // Counts cycles with neither an accepted input nor a result.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_single_elements();
    send_word('0, 1'b1);
    send_word({ValueW{1'b1}}, 1'b1);
    send_word(ValueW'(7), 1'b1);
    wait_drained();
  endtask

  task automatic test_extremes_and_zeros();
    send_word('0, 1'b0);
    send_word('0, 1'b0);
    send_word('0, 1'b1);
    send_word({ValueW{1'b1}}, 1'b0);
    send_word('0, 1'b0);
    send_word(ValueW'(1_000_000_000), 1'b0);
    send_word(ValueW'(999_999_999), 1'b0);
    send_word(ValueW'(10), 1'b0);
    send_word(ValueW'(10), 1'b1);
    wait_drained();
  endtask

  task automatic test_store_full();
    // Words past the store capacity are dropped, the closing word among them.
    for (int i = 0; i < MaxElems + 3; i++)
      send_word(ValueW'($urandom_range(0, 99)), i == MaxElems + 2);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < 150) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      send_random_set(n, 1'($urandom_range(0, 1)));
      sent += n;
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_single_elements();
    test_extremes_and_zeros();
    test_store_full();
    test_random_sets();
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (errors == 0 && sorted_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
